>>> rtl/core/sha1h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types, constants and helper functions of the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

	localparam int QDEPTH = 16;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [3:0] LEN_HI_WORD = 4'd14;
	localparam logic [3:0] LEN_LO_WORD = 4'd15;

	localparam logic [6:0] ROUND_LAST_LOAD = 7'd15;
	localparam logic [6:0] ROUND_LAST      = 7'd79;

	localparam logic [2:0] DIGEST_LAST = 3'd4;

	// One message word on its way from the front end to the compression engine.
	typedef struct packed {
		logic        last;   // closes the final block of a message
		logic [31:0] word;
	} q_word_t;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0:    v = IV0;
			3'd1:    v = IV1;
			3'd2:    v = IV2;
			3'd3:    v = IV3;
			default: v = IV4;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/sha1h_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_queue
// Small word queue between the byte front end and the compression engine.
// ----------------------------------------------------------------------------
module sha1h_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sha1h_pkg::q_word_t push_data,
	output logic              full,
	output logic              not_empty,
	input  logic              pop,
	output sha1h_pkg::q_word_t pop_data
);
	import sha1h_pkg::*;

	q_word_t           mem_q [QDEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QAW:0]      count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == (QAW+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/sha1h_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_front
// Takes byte requests, packs them into big-endian words, keeps the byte count
// and generates the message padding and length words.
// ----------------------------------------------------------------------------
module sha1h_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_has_byte,
	input  logic               in_end,
	output logic               q_push,
	output sha1h_pkg::q_word_t q_data,
	input  logic               q_full
);
	import sha1h_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_PAD  = 2'b10
	} front_state_t;

	front_state_t state_q;
	logic [63:0]  count_q;
	logic [31:0]  acc_q;
	logic [63:0]  bits_q;
	logic [3:0]   widx_q;
	logic         first_q;
	logic         wrap_q;

	logic         accept;
	logic [63:0]  count_nxt;
	logic [31:0]  pad_first_word;
	logic         len_slot;
	logic         pad_last;

	assign in_ready  = (state_q == F_IDLE) && !q_full;
	assign accept    = in_valid && in_ready;
	assign count_nxt = in_has_byte ? count_q + 64'd1 : count_q;

	// The first padding word holds the bytes already gathered, then 0x80.
	always_comb begin
		case (count_q[1:0])
			2'd0:    pad_first_word = {PAD_BYTE, 24'd0};
			2'd1:    pad_first_word = {acc_q[7:0], PAD_BYTE, 16'd0};
			2'd2:    pad_first_word = {acc_q[15:0], PAD_BYTE, 8'd0};
			default: pad_first_word = {acc_q[23:0], PAD_BYTE};
		endcase
	end

	assign len_slot = !first_q && !wrap_q;
	assign pad_last = len_slot && (widx_q == LEN_LO_WORD);

	always_comb begin
		q_push      = 1'b0;
		q_data.last = 1'b0;
		q_data.word = {acc_q[23:0], in_byte};
		case (state_q)
			F_IDLE: begin
				q_push = accept && in_has_byte && (count_q[1:0] == 2'd3);
			end
			F_PAD: begin
				q_push      = !q_full;
				q_data.last = pad_last;
				if (first_q) begin
					q_data.word = pad_first_word;
				end else if (len_slot && widx_q == LEN_HI_WORD) begin
					q_data.word = bits_q[63:32];
				end else if (pad_last) begin
					q_data.word = bits_q[31:0];
				end else begin
					q_data.word = '0;
				end
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && in_has_byte) begin
			acc_q <= {acc_q[23:0], in_byte};
		end
		if (accept && in_end) begin
			bits_q <= {count_nxt[60:0], 3'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			count_q <= '0;
			widx_q  <= '0;
			first_q <= 1'b0;
			wrap_q  <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						count_q <= count_nxt;
						if (in_end) begin
							state_q <= F_PAD;
							widx_q  <= count_nxt[5:2];
							first_q <= 1'b1;
							// no room for the length after 0x80: one more block
							wrap_q  <= (count_nxt[5:2] >= LEN_HI_WORD);
						end
					end
				end
				F_PAD: begin
					if (!q_full) begin
						first_q <= 1'b0;
						widx_q  <= widx_q + 4'd1;
						if (widx_q == LEN_LO_WORD) begin
							wrap_q <= 1'b0;
						end
						if (pad_last) begin
							state_q <= F_IDLE;
							count_q <= '0;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/sha1h_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_engine
// SHA-1 compression, one round per cycle when fed; chaining update, digest out.
// ----------------------------------------------------------------------------
module sha1h_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  sha1h_pkg::q_word_t q_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        out_word,
	output logic [2:0]         out_index,
	output logic               out_last
);
	import sha1h_pkg::*;

	typedef enum logic [3:0] {
		B_LOAD = 4'b0001,
		B_EXP  = 4'b0010,
		B_ADD  = 4'b0100,
		B_EMIT = 4'b1000
	} back_state_t;

	back_state_t state_q;
	logic [6:0]  rnd_q;
	logic        fin_q;
	logic [2:0]  idx_q;
	logic [31:0] chain_q [5];
	logic [31:0] s_q     [5];
	logic [31:0] sched_q [16];

	logic        round_en;
	logic [31:0] w_exp;
	logic [31:0] w_cur;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] tmp;
	logic        out_free;

	assign q_pop    = (state_q == B_LOAD);
	assign round_en = ((state_q == B_LOAD) && q_valid) || (state_q == B_EXP);
	assign w_exp    = rotl1(sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0]);
	assign w_cur    = (state_q == B_LOAD) ? q_data.word : w_exp;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f_val = s_q[3] ^ (s_q[1] & (s_q[2] ^ s_q[3]));
			k_val = K0;
		end else if (rnd_q < 7'd40) begin
			f_val = s_q[1] ^ s_q[2] ^ s_q[3];
			k_val = K1;
		end else if (rnd_q < 7'd60) begin
			f_val = (s_q[1] & s_q[2]) | (s_q[3] & (s_q[1] | s_q[2]));
			k_val = K2;
		end else begin
			f_val = s_q[1] ^ s_q[2] ^ s_q[3];
			k_val = K3;
		end
	end

	assign tmp = rotl5(s_q[0]) + f_val + s_q[4] + k_val + w_cur;

	always_ff @(posedge clk) begin
		if (round_en) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= w_cur;
		end
		if ((state_q == B_EMIT) && out_free) begin
			out_word  <= chain_q[idx_q];
			out_index <= idx_q;
			out_last  <= (idx_q == DIGEST_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_LOAD;
			rnd_q     <= '0;
			fin_q     <= 1'b0;
			idx_q     <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= iv_word(3'(i));
				s_q[i]     <= iv_word(3'(i));
			end
		end else begin
			// While emitting, the emit branch below reloads the output register.
			if (out_valid && out_ready && (state_q != B_EMIT)) begin
				out_valid <= 1'b0;
			end
			if (round_en) begin
				s_q[0] <= tmp;
				s_q[1] <= s_q[0];
				s_q[2] <= rotl30(s_q[1]);
				s_q[3] <= s_q[2];
				s_q[4] <= s_q[3];
				rnd_q  <= rnd_q + 7'd1;
			end
			case (state_q)
				B_LOAD: begin
					if (q_valid && rnd_q == ROUND_LAST_LOAD) begin
						fin_q   <= q_data.last;
						state_q <= B_EXP;
					end
				end
				B_EXP: begin
					if (rnd_q == ROUND_LAST) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= chain_q[i] + s_q[i];
						s_q[i]     <= chain_q[i] + s_q[i];
					end
					rnd_q   <= '0;
					idx_q   <= '0;
					state_q <= fin_q ? B_EMIT : B_LOAD;
				end
				B_EMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						idx_q     <= idx_q + 3'd1;
						if (idx_q == DIGEST_LAST) begin
							for (int i = 0; i < 5; i++) begin
								chain_q[i] <= iv_word(3'(i));
								s_q[i]     <= iv_word(3'(i));
							end
							fin_q   <= 1'b0;
							state_q <= B_LOAD;
						end
					end
				end
				default: begin
					state_q <= B_LOAD;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/sha1_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 message digest over a stream of bytes, one request per byte.
// ----------------------------------------------------------------------------
// Each slave request may carry one message byte (tuser high) and may close the
// message (tlast high). Bytes are taken at up to one per cycle; when a message
// closes, the block pads it, finishes the last block or two, and returns the
// five digest words H0 to H4 as five master requests, the fifth marked with
// tlast, before starting over from the initial hash values. A request with
// tlast and no byte is allowed, so an empty message gives the digest of the
// empty string. A front end packs bytes into 32-bit words and writes them,
// together with the padding and the 64-bit bit length, into a sixteen-word
// queue. A compression engine drains the queue, running one SHA-1 round per
// cycle, a loading round waiting while the queue is empty. The first sixteen
// rounds take their words straight from the queue, the other 64 expand the
// schedule in a sixteen-word shift line, and one more step adds the result
// into the chaining words. The queue holds the next block while the current
// one compresses, so sustained input is limited by the single round adder of
// the engine. Closing a message writes the padding and length words, runs
// one or two blocks of compression and returns the digest; the front end
// takes no byte while it is writing the padding.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] has_byte
	input  logic        s_tlast,   // end_of_message
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_tlast    // last_word
);
	import sha1h_pkg::*;

	q_word_t     push_data;
	q_word_t     pop_data;
	logic        q_push;
	logic        q_full;
	logic        q_not_empty;
	logic        q_pop;
	logic [31:0] digest_word;
	logic [2:0]  word_index;

	sha1h_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_byte     (s_tdata),
		.in_has_byte (s_tuser),
		.in_end      (s_tlast),
		.q_push      (q_push),
		.q_data      (push_data),
		.q_full      (q_full)
	);

	sha1h_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.pop_data  (pop_data)
	);

	sha1h_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_pop     (q_pop),
		.q_data    (pop_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (digest_word),
		.out_index (word_index),
		.out_last  (m_tlast)
	);

	assign m_tdata = {5'd0, word_index, digest_word};

endmodule
